@@ rtl/core/io_port_range_decoder_core_assert.svh @@
// Assertion macros shared by the port range decoder RTL.
`ifndef IO_PORT_RANGE_DECODER_CORE_ASSERT_SVH
`define IO_PORT_RANGE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IOPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IOPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/iopr_pkg.sv @@
// Types, codes and helpers for the I/O port range decoder.
package iopr_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_BITS = 6;

  typedef enum logic [1:0] {
    MODE_MAP   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_BAD      = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic [2:0] SIZE_BYTE  = 3'd1;
  localparam logic [2:0] SIZE_HALF  = 3'd2;
  localparam logic [2:0] SIZE_WORD  = 3'd4;

  localparam logic [31:0] FILL_BYTE = 32'h0000_00ff;
  localparam logic [31:0] FILL_HALF = 32'h0000_ffff;
  localparam logic [31:0] FILL_WORD = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic [15:0] range_last;
    logic [2:0]  access_size;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_BITS-1:0] slot;
    logic [31:0]          data;
  } result_t;

  // Parallel lookup outcome from the slot table
  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] hit_idx;
    logic                 free;
    logic [SLOT_BITS-1:0] free_idx;
  } lookup_t;

  // Slot claim request towards the table
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] idx;
    logic [15:0]          first;
    logic [15:0]          last;
  } claim_t;

  function automatic logic size_valid(input logic [2:0] sz);
    logic ok;
    case (sz)
      SIZE_BYTE, SIZE_HALF, SIZE_WORD: ok = 1'b1;
      default:                         ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [31:0] size_fill(input logic [2:0] sz);
    logic [31:0] f;
    case (sz)
      SIZE_BYTE: f = FILL_BYTE;
      SIZE_HALF: f = FILL_HALF;
      default:   f = FILL_WORD;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/iopr_if.sv @@
// Valid/ready channel interfaces for decoder requests and results.
interface iopr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] port;
  logic [15:0] range_last;
  logic [2:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, mode, port, range_last, access_size, write_data,
                  input ready);
  modport sink   (input valid, mode, port, range_last, access_size, write_data,
                  output ready);
endinterface

interface iopr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot;
  logic [31:0] data;

  modport source (output valid, status, slot, data, input ready);
  modport sink   (input valid, status, slot, data, output ready);
endinterface

@@ rtl/core/iopr_table.sv @@
// Slot table: range storage, parallel port match and free-slot search.
module iopr_table #(
  parameter int SLOTS = iopr_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      port,
  input  iopr_pkg::claim_t claim,
  output iopr_pkg::lookup_t lookup
);
  import iopr_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] used_r;
  logic [15:0]      first_r [SLOTS];
  logic [15:0]      last_r  [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (claim.en) begin
      used_r[claim.idx[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim.en) begin
      first_r[claim.idx[IDX_W-1:0]] <= claim.first;
      last_r[claim.idx[IDX_W-1:0]]  <= claim.last;
    end
  end

  // Walk downwards so the lowest matching slot wins
  always_comb begin
    lookup = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && (port >= first_r[i]) && (port <= last_r[i])) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = SLOT_BITS'(i);
      end
      if (!used_r[i]) begin
        lookup.free     = 1'b1;
        lookup.free_idx = SLOT_BITS'(i);
      end
    end
  end

endmodule

@@ rtl/core/iopr_resolve.sv @@
// Per-item decision: status, slot and data, plus any slot claim.
module iopr_resolve (
  input  iopr_pkg::item_t   item,
  input  iopr_pkg::lookup_t lookup,
  output iopr_pkg::result_t result,
  output logic              claim_req
);
  import iopr_pkg::*;

  always_comb begin
    result    = '0;
    claim_req = 1'b0;
    case (item.mode)
      MODE_MAP: begin
        if (item.port > item.range_last) begin
          result.status = ST_BAD;
        end else if (!lookup.free) begin
          result.status = ST_FULL;
        end else begin
          result.status = ST_OK;
          result.slot   = lookup.free_idx;
          claim_req     = 1'b1;
        end
      end
      MODE_READ: begin
        if (!size_valid(item.access_size)) begin
          result.status = ST_BAD;
        end else if (lookup.hit) begin
          result.status = ST_OK;
          result.slot   = lookup.hit_idx;
        end else begin
          result.status = ST_UNMAPPED;
          result.data   = size_fill(item.access_size);
        end
      end
      MODE_WRITE: begin
        if (!size_valid(item.access_size)) begin
          result.status = ST_BAD;
        end else if (lookup.hit) begin
          result.status = ST_OK;
          result.slot   = lookup.hit_idx;
          result.data   = item.write_data;
        end else begin
          result.status = ST_UNMAPPED;
        end
      end
      default: begin
        result.status = ST_BAD;
      end
    endcase
  end

endmodule

@@ rtl/core/io_port_range_decoder_core.sv @@
// I/O port range decoder: items pass through an input register, a parallel
// compare against every slot and a result register. Each item gives exactly
// one result, via the input register and then the result register. The table
// is updated as the item leaves the input register, so a range mapped by one
// item is seen by the very next one. Sustained rate is one item per clock
// unless the output stalls; the slot compare and lowest-index select set the path.
module io_port_range_decoder_core #(
  parameter int SLOTS = iopr_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  iopr_in_if.sink    in_ch,
  iopr_out_if.source out_ch
);
  import iopr_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;

  logic    out_free;
  logic    s1_adv;
  logic    in_take;
  lookup_t lookup;
  result_t res_nxt;
  logic    claim_req;
  claim_t  claim;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{mode: in_ch.mode, port: in_ch.port, range_last: in_ch.range_last,
                     access_size: in_ch.access_size, write_data: in_ch.write_data};
    end
  end

  iopr_table #(.SLOTS(SLOTS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .port   (s1_item_r.port),
    .claim  (claim),
    .lookup (lookup)
  );

  iopr_resolve u_resolve (
    .item      (s1_item_r),
    .lookup    (lookup),
    .result    (res_nxt),
    .claim_req (claim_req)
  );

  assign claim = '{en: claim_req && s1_adv, idx: lookup.free_idx,
                   first: s1_item_r.port, last: s1_item_r.range_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_res_r.status;
  assign out_ch.slot   = out_res_r.slot;
  assign out_ch.data   = out_res_r.data;

`include "io_port_range_decoder_core_assert.svh"

  `IOPR_ASSERT_NOW(a_ready_only_when_full, !in_ch.ready, s1_valid_r, "input stalled with empty stage")
  `IOPR_ASSERT_NEXT(a_s1_holds, s1_valid_r && !out_free, s1_valid_r && $stable(s1_item_r), "stalled item lost")
  `IOPR_ASSERT_NOW(a_slot_in_range, out_ch.valid, $unsigned(out_ch.slot) < SLOTS, "slot index out of range")

endmodule
